FILE: hw/rtl/devicetree_structure_walker_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the device tree structure walker
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef DEVICETREE_STRUCTURE_WALKER_UNIT_MACROS_SVH
`define DEVICETREE_STRUCTURE_WALKER_UNIT_MACROS_SVH

// A condition that must hold at every clock edge out of reset.
`define DTSW_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

// A consequence that must hold at the clock edge after the antecedent.
`define DTSW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/dtsw_pkg.sv
// ----------------------------------------------------------------------------
// Device tree structure walker package
// Structure block tokens, event codes and beat layouts.
// ----------------------------------------------------------------------------
`default_nettype none

package dtsw_pkg;

  localparam logic [31:0] TOK_BEGIN_NODE = 32'd1;
  localparam logic [31:0] TOK_END_NODE   = 32'd2;
  localparam logic [31:0] TOK_PROP       = 32'd3;
  localparam logic [31:0] TOK_NOP        = 32'd4;
  localparam logic [31:0] TOK_END        = 32'd9;

  typedef enum logic [2:0] {
    EV_NONE   = 3'd0,
    EV_BEGIN  = 3'd1,
    EV_NAME   = 3'd2,
    EV_HEADER = 3'd3,
    EV_DATA   = 3'd4,
    EV_END    = 3'd5,
    EV_ERROR  = 3'd6
  } event_t;

  localparam int unsigned DEPTH_W    = 7;
  localparam int unsigned DEPTH_CAP  = 127;
  localparam int unsigned OUT_DATA_W = 112;

  typedef struct packed {
    logic [2:0]         valid_bytes;
    logic [31:0]        data_word;
    logic [31:0]        name_offset;
    logic [31:0]        prop_length;
    logic [DEPTH_W-1:0] depth;
    event_t             event_res;
  } result_t;

endpackage

`default_nettype wire

FILE: hw/rtl/devicetree_structure_walker_unit.sv
// ----------------------------------------------------------------------------
// Device tree structure walker
// Parses the structure block of a flattened device tree, one event per word.
// ----------------------------------------------------------------------------
// The in_ stream carries one big-endian structure word per beat, with tlast
// on the final word of the block. The out_ stream returns exactly one event
// beat for every input beat, in order.
// A word is captured in an input register and, in the next stage, decoded
// against the parse state in a single pass into the result register, so the
// event beat is presented from the result register after its word has passed
// through the input register. Throughput is one word per cycle while the
// receiver keeps out_tready high; the parse state is updated once per word
// as it enters the result register, which bounds the rate.
// When the receiver stalls, the result register holds its beat and the input
// register can still take one more word; in_tready drops only when both are
// full. Reset (rst_n low, synchronous) empties both registers and returns the
// parser to waiting for the root node. The beat carrying tlast always
// returns the parser to that state after its event is formed, and reports an
// error if the tree was left incomplete.
// ----------------------------------------------------------------------------
`default_nettype none

`include "devicetree_structure_walker_unit_macros.svh"

module devicetree_structure_walker_unit
  import dtsw_pkg::*;
#(
  parameter int unsigned MAX_DEPTH = 64
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output      logic                  in_tready,
  input  wire logic [31:0]           in_tdata,   // word[31:0]
  input  wire logic                  in_tlast,   // last_word
  output      logic                  out_tvalid,
  input  wire logic                  out_tready,
  output      logic [OUT_DATA_W-1:0] out_tdata   // event_res[2:0], depth[9:3],
                                                 // prop_length[41:10],
                                                 // name_offset[73:42],
                                                 // data_word[105:74],
                                                 // valid_bytes[108:106], zero
);

  localparam int unsigned DEPTH_LIMIT = (MAX_DEPTH > DEPTH_CAP) ? DEPTH_CAP : MAX_DEPTH;
  localparam logic [DEPTH_W-1:0] DEPTH_LIMIT_V = DEPTH_LIMIT[DEPTH_W-1:0];

  typedef enum logic [3:0] {
    PH_START,
    PH_NAME,
    PH_PROPS,
    PH_LEN,
    PH_OFF,
    PH_DATA,
    PH_CHILDREN,
    PH_DONE,
    PH_ERROR
  } phase_t;

  logic               s1_valid_r;
  logic [31:0]        s1_word_r;
  logic               s1_last_r;
  logic               out_valid_r;
  result_t            res_r;
  result_t            res_nxt;
  phase_t             phase_r;
  phase_t             phase_nxt;
  phase_t             phase_step;
  logic [DEPTH_W-1:0] depth_r;
  logic [DEPTH_W-1:0] depth_nxt;
  logic [DEPTH_W-1:0] depth_step;
  logic [31:0]        pend_len_r;
  logic [31:0]        pend_len_nxt;
  logic [31:0]        pend_len_step;
  logic [31:0]        bytes_left_r;
  logic [31:0]        bytes_left_nxt;
  logic [31:0]        bytes_left_step;
  logic               s2_adv;
  logic               s2_fire;
  logic               in_fire;

  assign s2_adv    = !out_valid_r || out_tready;
  assign s2_fire   = s1_valid_r && s2_adv;
  assign in_tready = !s1_valid_r || s2_adv;
  assign in_fire   = in_tvalid && in_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W - $bits(result_t)){1'b0}}, res_r};

  always_comb begin
    logic [31:0] w;
    logic [2:0]  vb;
    w               = s1_word_r;
    vb              = 3'd0;
    phase_step      = phase_r;
    depth_step      = depth_r;
    pend_len_step   = pend_len_r;
    bytes_left_step = bytes_left_r;
    res_nxt         = '0;
    res_nxt.event_res = EV_NONE;

    case (phase_r)
      PH_START: begin
        if (w == TOK_BEGIN_NODE) begin
          if (depth_r >= DEPTH_LIMIT_V) begin
            res_nxt.event_res = EV_ERROR;
            phase_step = PH_ERROR;
          end else begin
            depth_step = depth_r + 1'b1;
            res_nxt.event_res = EV_BEGIN;
            phase_step = PH_NAME;
          end
        end else if (w != TOK_NOP) begin
          res_nxt.event_res = EV_ERROR;
          phase_step = PH_ERROR;
        end
      end
      PH_NAME: begin
        res_nxt.event_res = EV_NAME;
        res_nxt.data_word = w;
        if (w[31:24] == 8'd0) begin
          vb = 3'd0;
        end else if (w[23:16] == 8'd0) begin
          vb = 3'd1;
        end else if (w[15:8] == 8'd0) begin
          vb = 3'd2;
        end else if (w[7:0] == 8'd0) begin
          vb = 3'd3;
        end else begin
          vb = 3'd4;
        end
        res_nxt.valid_bytes = vb;
        if (vb != 3'd4) begin
          phase_step = PH_PROPS;
        end
      end
      PH_PROPS, PH_CHILDREN: begin
        if (w == TOK_NOP) begin
          phase_step = phase_r;
        end else if (w == TOK_PROP && phase_r == PH_PROPS) begin
          phase_step = PH_LEN;
        end else if (w == TOK_BEGIN_NODE) begin
          if (depth_r >= DEPTH_LIMIT_V) begin
            res_nxt.event_res = EV_ERROR;
            phase_step = PH_ERROR;
          end else begin
            depth_step = depth_r + 1'b1;
            res_nxt.event_res = EV_BEGIN;
            phase_step = PH_NAME;
          end
        end else if (w == TOK_END_NODE) begin
          depth_step = depth_r - 1'b1;
          res_nxt.event_res = EV_END;
          phase_step = (depth_step == '0) ? PH_DONE : PH_CHILDREN;
        end else begin
          res_nxt.event_res = EV_ERROR;
          phase_step = PH_ERROR;
        end
      end
      PH_LEN: begin
        pend_len_step = w;
        phase_step = PH_OFF;
      end
      PH_OFF: begin
        res_nxt.event_res   = EV_HEADER;
        res_nxt.prop_length = pend_len_r;
        res_nxt.name_offset = w;
        bytes_left_step     = pend_len_r;
        phase_step = (pend_len_r != 32'd0) ? PH_DATA : PH_PROPS;
      end
      PH_DATA: begin
        res_nxt.event_res = EV_DATA;
        res_nxt.data_word = w;
        vb = (bytes_left_r > 32'd4) ? 3'd4 : bytes_left_r[2:0];
        res_nxt.valid_bytes = vb;
        bytes_left_step = bytes_left_r - {29'd0, vb};
        if (bytes_left_step == 32'd0) begin
          phase_step = PH_PROPS;
        end
      end
      PH_DONE: begin
        if (w != TOK_NOP && w != TOK_END) begin
          res_nxt.event_res = EV_ERROR;
          phase_step = PH_ERROR;
        end
      end
      default: begin
        phase_step = PH_ERROR;
      end
    endcase

    if (s1_last_r && phase_step != PH_DONE && phase_step != PH_ERROR) begin
      res_nxt = '0;
      res_nxt.event_res = EV_ERROR;
    end
    res_nxt.depth = depth_step;

    if (s1_last_r) begin
      phase_nxt      = PH_START;
      depth_nxt      = '0;
      pend_len_nxt   = 32'd0;
      bytes_left_nxt = 32'd0;
    end else begin
      phase_nxt      = phase_step;
      depth_nxt      = depth_step;
      pend_len_nxt   = pend_len_step;
      bytes_left_nxt = bytes_left_step;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      phase_r      <= PH_START;
      depth_r      <= '0;
      pend_len_r   <= 32'd0;
      bytes_left_r <= 32'd0;
    end else begin
      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (s2_fire) begin
        s1_valid_r <= 1'b0;
      end
      if (s2_fire) begin
        out_valid_r  <= 1'b1;
        phase_r      <= phase_nxt;
        depth_r      <= depth_nxt;
        pend_len_r   <= pend_len_nxt;
        bytes_left_r <= bytes_left_nxt;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_word_r <= in_tdata;
      s1_last_r <= in_tlast;
    end
    if (s2_fire) begin
      res_r <= res_nxt;
    end
  end

  `DTSW_ASSERT_ALWAYS(a_depth_bound, depth_r <= DEPTH_LIMIT_V,
    "node depth exceeds the configured limit")

  `DTSW_ASSERT_ALWAYS(a_done_at_root, phase_r != PH_DONE || depth_r == '0,
    "tree marked complete with nodes still open")

  `DTSW_ASSERT_ALWAYS(a_open_depth,
    !(phase_r == PH_NAME || phase_r == PH_PROPS || phase_r == PH_LEN ||
      phase_r == PH_OFF || phase_r == PH_DATA || phase_r == PH_CHILDREN) ||
    depth_r != '0,
    "inside a node with zero depth")

  `DTSW_ASSERT_ALWAYS(a_data_left, phase_r != PH_DATA || bytes_left_r != 32'd0,
    "property data phase with no bytes left")

  `DTSW_ASSERT_NEXT(a_last_restart, s2_fire && s1_last_r,
    phase_r == PH_START && depth_r == '0 && out_valid_r,
    "walker did not restart after the last word")

endmodule

`default_nettype wire

FILE: sim/devicetree_structure_walker_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Device tree structure walker testbench
// Streams structure block words into the walker and compares every event
// beat against a cycle-free model of the parser in this file, or against the
// short table of hand-picked words that opens the run. Generated trees follow:
// mostly well-formed with random names and properties, some with a corrupted
// word or a truncated tail, a few deep chains at and past the nesting limit,
// and a few blocks of plain noise. Both stream sides idle at random.
// ----------------------------------------------------------------------------
module devicetree_structure_walker_unit_tb
  import dtsw_pkg::*;
();

  localparam int unsigned DEPTH_LIMIT  = 64;
  localparam int unsigned WALK_LIMIT   = (DEPTH_LIMIT > DEPTH_CAP) ? DEPTH_CAP : DEPTH_LIMIT;
  localparam int unsigned RANDOM_WORDS = 1250;

  typedef enum logic [3:0] {
    WP_ROOT, WP_NAME, WP_PROPS, WP_LEN, WP_OFF, WP_DATA, WP_CHILDREN, WP_DONE, WP_ERROR
  } walk_phase_t;

  typedef struct {
    logic [31:0] word;
    logic        last;
    bit          typed;
    result_t     want;
  } walk_row_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [31:0]           in_tdata   = '0;
  logic                  in_tlast   = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  walk_phase_t wphase  = WP_ROOT;
  logic [6:0]  wdepth  = '0;
  logic [31:0] wlength = '0;
  logic [31:0] wleft   = '0;

  result_t     event_q[$];
  walk_row_t   dir_rows[$];
  logic [31:0] block_words[$];
  int          fails        = 0;
  int          words_sent   = 0;
  int          blocks_sent  = 0;
  int          error_events = 0;
  int          deepest      = 0;
  bit          steady       = 1'b0;

  devicetree_structure_walker_unit #(
    .MAX_DEPTH(DEPTH_LIMIT)
  ) u_top (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tlast(in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("devicetree_structure_walker_unit_tb: FAIL");
    $finish;
  end

  function automatic void restart_walk();
    wphase  = WP_ROOT;
    wdepth  = '0;
    wlength = '0;
    wleft   = '0;
  endfunction

  function automatic event_t enter_node();
    if (wdepth >= WALK_LIMIT) begin
      wphase = WP_ERROR;
      return EV_ERROR;
    end
    wdepth = wdepth + 7'd1;
    wphase = WP_NAME;
    return EV_BEGIN;
  endfunction

  function automatic result_t walk_predict(logic [31:0] w, logic last);
    result_t r;
    bit      found;
    int      k;
    r = '0;
    r.event_res = EV_NONE;
    found = 1'b0;
    case (wphase)
      WP_ROOT: begin
        if (w == TOK_BEGIN_NODE) begin
          r.event_res = enter_node();
        end else if (w != TOK_NOP) begin
          r.event_res = EV_ERROR;
          wphase = WP_ERROR;
        end
      end
      WP_NAME: begin
        r.event_res   = EV_NAME;
        r.data_word   = w;
        r.valid_bytes = 3'd4;
        for (k = 0; k < 4; k++) begin
          if (w[31-8*k -: 8] == 8'h00 && !found) begin
            r.valid_bytes = 3'(k);
            found = 1'b1;
          end
        end
        if (found) wphase = WP_PROPS;
      end
      WP_PROPS, WP_CHILDREN: begin
        if (w == TOK_NOP) begin
          r.event_res = EV_NONE;
        end else if (w == TOK_PROP && wphase == WP_PROPS) begin
          wphase = WP_LEN;
        end else if (w == TOK_BEGIN_NODE) begin
          r.event_res = enter_node();
        end else if (w == TOK_END_NODE) begin
          wdepth = wdepth - 7'd1;
          r.event_res = EV_END;
          wphase = (wdepth == 7'd0) ? WP_DONE : WP_CHILDREN;
        end else begin
          r.event_res = EV_ERROR;
          wphase = WP_ERROR;
        end
      end
      WP_LEN: begin
        wlength = w;
        wphase  = WP_OFF;
      end
      WP_OFF: begin
        r.event_res   = EV_HEADER;
        r.prop_length = wlength;
        r.name_offset = w;
        wleft  = wlength;
        wphase = (wleft != 32'd0) ? WP_DATA : WP_PROPS;
      end
      WP_DATA: begin
        r.event_res   = EV_DATA;
        r.data_word   = w;
        r.valid_bytes = (wleft > 32'd4) ? 3'd4 : 3'(wleft);
        wleft = wleft - 32'(r.valid_bytes);
        if (wleft == 32'd0) wphase = WP_PROPS;
      end
      WP_DONE: begin
        if (w != TOK_NOP && w != TOK_END) begin
          r.event_res = EV_ERROR;
          wphase = WP_ERROR;
        end
      end
      default: wphase = WP_ERROR;
    endcase
    if (last && wphase != WP_DONE && wphase != WP_ERROR) begin
      r = '0;
      r.event_res = EV_ERROR;
    end
    r.depth = wdepth;
    if (last) restart_walk();
    return r;
  endfunction

  function automatic walk_row_t mk_row(logic [31:0] w, logic l, bit typed, event_t e, int d);
    walk_row_t row;
    row.word  = w;
    row.last  = l;
    row.typed = typed;
    row.want  = '0;
    row.want.event_res = e;
    row.want.depth     = 7'(d);
    return row;
  endfunction

  task automatic drive_word(input logic [31:0] w, input logic l, input bit typed,
                            input result_t want);
    result_t pred;
    if (!steady && $urandom_range(0, 99) < 10) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= w;
    in_tlast  <= l;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pred = walk_predict(w, l);
    if (pred.event_res == EV_ERROR) error_events++;
    if (int'(pred.depth) > deepest) deepest = int'(pred.depth);
    event_q.push_back(typed ? want : pred);
    words_sent++;
  endtask

  task automatic send_block();
    int i;
    for (i = 0; i < block_words.size(); i++) begin
      drive_word(block_words[i], i == block_words.size() - 1, 1'b0, '0);
    end
    blocks_sent++;
  endtask

  task automatic gen_name();
    int          n;
    int          k;
    logic [31:0] w;
    if ($urandom_range(0, 99) < 5) block_words.push_back($urandom);
    n = $urandom_range(0, 11);
    w = '0;
    for (k = 0; k <= n; k++) begin
      w = {w[23:0], (k == n) ? 8'h00 : 8'($urandom_range(1, 255))};
      if (k % 4 == 3) begin
        block_words.push_back(w);
        w = '0;
      end
    end
    if ((n + 1) % 4 != 0) block_words.push_back(w << (8 * (4 - (n + 1) % 4)));
  endtask

  task automatic gen_tree();
    int          d;
    int          maxd;
    int          budget;
    int          r;
    int          k;
    int          cut;
    logic [31:0] len;
    logic [31:0] pick;
    bit          had_child [0:7];
    block_words.delete();
    maxd   = $urandom_range(1, 4);
    budget = $urandom_range(2, 14);
    if ($urandom_range(0, 99) < 20) block_words.push_back(TOK_NOP);
    block_words.push_back(TOK_BEGIN_NODE);
    gen_name();
    d = 1;
    had_child[1] = 1'b0;
    while (d > 0) begin
      r = $urandom_range(0, 99);
      if (budget == 0 || r >= 80) begin
        block_words.push_back(TOK_END_NODE);
        d--;
      end else begin
        budget--;
        if (r < 8) begin
          block_words.push_back(TOK_NOP);
        end else if (r < 50 && !had_child[d]) begin
          block_words.push_back(TOK_PROP);
          len = ($urandom_range(0, 99) < 4) ? $urandom : 32'($urandom_range(0, 17));
          block_words.push_back(len);
          block_words.push_back($urandom);
          if (len <= 32'd17) begin
            for (k = 0; k < (int'(len) + 3) / 4; k++) block_words.push_back($urandom);
          end else begin
            repeat ($urandom_range(1, 3)) block_words.push_back($urandom);
          end
        end else if (d < maxd) begin
          had_child[d] = 1'b1;
          d++;
          had_child[d] = 1'b0;
          block_words.push_back(TOK_BEGIN_NODE);
          gen_name();
        end else begin
          block_words.push_back(TOK_END_NODE);
          d--;
        end
      end
    end
    repeat ($urandom_range(0, 2)) block_words.push_back($urandom_range(0, 1) ? TOK_END : TOK_NOP);
    r = $urandom_range(0, 99);
    if (r < 10) begin
      case ($urandom_range(0, 5))
        0:       pick = TOK_BEGIN_NODE;
        1:       pick = TOK_END_NODE;
        2:       pick = TOK_PROP;
        3:       pick = TOK_NOP;
        4:       pick = TOK_END;
        default: pick = $urandom;
      endcase
      block_words[$urandom_range(0, block_words.size() - 1)] = pick;
    end else if (r < 16 && block_words.size() > 1) begin
      cut = $urandom_range(1, block_words.size() - 1);
      while (block_words.size() > cut) void'(block_words.pop_back());
    end
  endtask

  task automatic gen_chain(input bit overflow);
    int k;
    block_words.delete();
    for (k = 0; k < WALK_LIMIT + overflow; k++) begin
      block_words.push_back(TOK_BEGIN_NODE);
      block_words.push_back(32'h0);
    end
    if (overflow) begin
      block_words.push_back(TOK_NOP);
    end else begin
      for (k = 0; k < WALK_LIMIT; k++) block_words.push_back(TOK_END_NODE);
    end
  endtask

  always @(posedge clk) begin
    out_tready <= steady || ($urandom_range(0, 99) >= 10);
  end

  always @(posedge clk) begin : result_check
    result_t got;
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[$bits(result_t)-1:0];
      if (event_q.size() == 0) begin
        $error("event beat with no expectation pending");
        fails++;
      end else begin
        want = event_q.pop_front();
        if (got.event_res !== want.event_res) begin
          $error("event_res: expected %0d, got %0d", want.event_res, got.event_res);
          fails++;
        end
        if (got.depth !== want.depth) begin
          $error("depth: expected %0d, got %0d", want.depth, got.depth);
          fails++;
        end
        if (got.prop_length !== want.prop_length) begin
          $error("prop_length: expected %h, got %h", want.prop_length, got.prop_length);
          fails++;
        end
        if (got.name_offset !== want.name_offset) begin
          $error("name_offset: expected %h, got %h", want.name_offset, got.name_offset);
          fails++;
        end
        if (got.data_word !== want.data_word) begin
          $error("data_word: expected %h, got %h", want.data_word, got.data_word);
          fails++;
        end
        if (got.valid_bytes !== want.valid_bytes) begin
          $error("valid_bytes: expected %0d, got %0d", want.valid_bytes, got.valid_bytes);
          fails++;
        end
      end
    end
  end

  initial begin
    int i;
    int blk;
    int base;
    int r;
    // NOP before the root, then a root with an empty name.
    dir_rows.push_back(mk_row(TOK_NOP, 1'b0, 1'b1, EV_NONE, 0));
    dir_rows.push_back(mk_row(TOK_BEGIN_NODE, 1'b0, 1'b1, EV_BEGIN, 1));
    dir_rows.push_back(mk_row(32'h0000_0000, 1'b0, 1'b0, EV_NONE, 0));
    // Zero-length property, then a five-byte one.
    dir_rows.push_back(mk_row(TOK_PROP, 1'b0, 1'b0, EV_NONE, 0));
    dir_rows.push_back(mk_row(32'h0000_0000, 1'b0, 1'b0, EV_NONE, 0));
    dir_rows.push_back(mk_row(32'hFFFF_FFFF, 1'b0, 1'b0, EV_NONE, 0));
    dir_rows.push_back(mk_row(TOK_PROP, 1'b0, 1'b0, EV_NONE, 0));
    dir_rows.push_back(mk_row(32'h0000_0005, 1'b0, 1'b0, EV_NONE, 0));
    dir_rows.push_back(mk_row(32'h0000_0000, 1'b0, 1'b0, EV_NONE, 0));
    dir_rows.push_back(mk_row(32'hFFFF_FFFF, 1'b0, 1'b0, EV_NONE, 0));
    dir_rows.push_back(mk_row(32'h1234_5678, 1'b0, 1'b0, EV_NONE, 0));
    // A child closes, so a following property is rejected.
    dir_rows.push_back(mk_row(TOK_BEGIN_NODE, 1'b0, 1'b1, EV_BEGIN, 2));
    dir_rows.push_back(mk_row(32'h6162_6300, 1'b0, 1'b0, EV_NONE, 0));
    dir_rows.push_back(mk_row(TOK_END_NODE, 1'b0, 1'b0, EV_NONE, 0));
    dir_rows.push_back(mk_row(TOK_PROP, 1'b0, 1'b1, EV_ERROR, 1));
    dir_rows.push_back(mk_row(TOK_END_NODE, 1'b1, 1'b1, EV_NONE, 1));
    // Garbage as the first word of a block.
    dir_rows.push_back(mk_row(32'hFFFF_FFFF, 1'b1, 1'b1, EV_ERROR, 0));
    // A long name, then an END token inside the node.
    dir_rows.push_back(mk_row(TOK_BEGIN_NODE, 1'b0, 1'b0, EV_NONE, 0));
    dir_rows.push_back(mk_row(32'h2F61_6263, 1'b0, 1'b0, EV_NONE, 0));
    dir_rows.push_back(mk_row(32'h00FF_FFFF, 1'b0, 1'b0, EV_NONE, 0));
    dir_rows.push_back(mk_row(TOK_END, 1'b0, 1'b1, EV_ERROR, 1));
    dir_rows.push_back(mk_row(TOK_NOP, 1'b1, 1'b1, EV_NONE, 1));
    // A block that stops right after the root opens.
    dir_rows.push_back(mk_row(TOK_BEGIN_NODE, 1'b1, 1'b1, EV_ERROR, 1));
    // A complete tree with trailing END and NOP words.
    dir_rows.push_back(mk_row(TOK_BEGIN_NODE, 1'b0, 1'b0, EV_NONE, 0));
    dir_rows.push_back(mk_row(32'h4142_0000, 1'b0, 1'b0, EV_NONE, 0));
    dir_rows.push_back(mk_row(TOK_END_NODE, 1'b0, 1'b1, EV_END, 0));
    dir_rows.push_back(mk_row(TOK_END, 1'b0, 1'b0, EV_NONE, 0));
    dir_rows.push_back(mk_row(TOK_NOP, 1'b1, 1'b1, EV_NONE, 0));

    restart_walk();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    for (i = 0; i < dir_rows.size(); i++) begin
      drive_word(dir_rows[i].word, dir_rows[i].last, dir_rows[i].typed, dir_rows[i].want);
    end

    base = words_sent;
    blk  = 0;
    while (words_sent - base < RANDOM_WORDS) begin
      steady = (words_sent - base >= 450) && (words_sent - base < 750);
      r = $urandom_range(0, 99);
      if (blk == 6 || blk == 40) begin
        gen_chain(1'b0);
      end else if (blk == 14 || blk == 55) begin
        gen_chain(1'b1);
      end else if (r < 4) begin
        block_words.delete();
        repeat ($urandom_range(1, 4)) block_words.push_back($urandom);
      end else begin
        gen_tree();
      end
      send_block();
      blk++;
    end
    steady = 1'b0;
    in_tvalid <= 1'b0;

    while (event_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Walked %0d words in %0d blocks: %0d error events, nesting down to depth %0d.",
             words_sent, blocks_sent, error_events, deepest);
    if (fails == 0) begin
      $display("devicetree_structure_walker_unit_tb: PASS");
    end else begin
      $display("devicetree_structure_walker_unit_tb: FAIL");
    end
    $finish;
  end

endmodule
